@@ sv/afc_pkg.sv @@
// Shared types and constants for the averaging reciprocal frequency counter.
`default_nettype none
package afc_pkg;

	// Field and state widths
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned SUM_W   = 36;
	localparam int unsigned CNT_W   = 4;

	// Number of valid periods averaged per result
	localparam logic [CNT_W-1:0] WINDOW = 4'd10;

	// Periods at or above this are glitches or wrapped garbage
	localparam logic [STAMP_W-1:0] PERIOD_LIMIT = 32'hFFFF_FFF0;

	// Tick rate after reset, in hertz
	localparam logic [STAMP_W-1:0] TICK_RATE_RST = 32'd1_000_000;

	// Divider: one quotient bit per cycle over the full sum width
	localparam int unsigned DIV_STEPS = SUM_W;
	localparam int unsigned DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'(DIV_STEPS - 1);

	// Window mean: sum / WINDOW, 12 dividend bits per cycle. Each digit is
	// (remainder:12 bits) * ceil(2^20 / WINDOW) >> 20, exact for any WINDOW
	// up to 15 since the digit operand stays below 15 * 4096.
	localparam int unsigned MEAN_DIG_W  = 12;
	localparam int unsigned MEAN_STEPS  = SUM_W / MEAN_DIG_W;
	localparam int unsigned MEAN_T_W    = CNT_W + MEAN_DIG_W;
	localparam int unsigned MEAN_SHIFT  = 20;
	localparam int unsigned MEAN_M_W    = 21;
	localparam int unsigned MEAN_PROD_W = MEAN_T_W + MEAN_M_W;
	localparam int unsigned MEAN_CNT_W  = 2;
	localparam logic [MEAN_M_W-1:0] MEAN_RECIP =
		MEAN_M_W'(((1 << MEAN_SHIFT) + int'(WINDOW) - 1) / int'(WINDOW));
	localparam logic [MEAN_CNT_W-1:0] MEAN_LAST = MEAN_CNT_W'(MEAN_STEPS - 1);

	// Queue between front and back
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = 1;
	localparam int unsigned Q_CNT_W = 2;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} afc_q_stat_t;

	// Divide request from the back controller
	typedef struct packed {
		logic               start;
		logic [SUM_W-1:0]   dividend;
		logic [STAMP_W-1:0] divisor;
	} afc_div_req_t;

	// Divide response
	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} afc_div_rsp_t;

endpackage
`default_nettype wire

@@ sv/afc_front.sv @@
// Front end: period extraction, glitch filter and window accumulation.
`default_nettype none
module afc_front (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [afc_pkg::STAMP_W-1:0]       capture_stamp,
	input  afc_pkg::afc_q_stat_t              q_stat,
	output logic                              q_push,
	output logic [afc_pkg::SUM_W-1:0]         q_data
);

	logic [afc_pkg::STAMP_W-1:0] prev_stamp_q;
	logic [afc_pkg::SUM_W-1:0]   sum_q;
	logic [afc_pkg::CNT_W-1:0]   cnt_q;

	logic [afc_pkg::STAMP_W-1:0] period;
	logic                        per_ok;
	logic [afc_pkg::SUM_W-1:0]   sum_next;
	logic [afc_pkg::CNT_W-1:0]   cnt_next;
	logic                        win_done;
	logic                        accept;

	// Period with modulo 2^32 wrap, filter, running sum
	always_comb begin
		period   = capture_stamp - prev_stamp_q;
		per_ok   = (period != '0) && (period < afc_pkg::PERIOD_LIMIT);
		sum_next = sum_q + afc_pkg::SUM_W'(period);
		cnt_next = cnt_q + afc_pkg::CNT_W'(1);
		win_done = (cnt_next == afc_pkg::WINDOW);
	end

	// Hold off while the queue cannot take another window
	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && per_ok && win_done;
	assign q_data   = sum_next;

	// Window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_stamp_q <= '0;
			sum_q        <= '0;
			cnt_q        <= '0;
		end else if (accept) begin
			prev_stamp_q <= capture_stamp;
			if (per_ok) begin
				if (win_done) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/afc_fifo.sv @@
// Short queue of completed window sums between front and back.
`default_nettype none
module afc_fifo (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           push,
	input  wire  [afc_pkg::SUM_W-1:0]     push_data,
	input  wire                           pop,
	output logic [afc_pkg::SUM_W-1:0]     pop_data,
	output afc_pkg::afc_q_stat_t          stat
);

	logic [afc_pkg::SUM_W-1:0]   mem_q [afc_pkg::Q_DEPTH];
	logic [afc_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [afc_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [afc_pkg::Q_CNT_W-1:0] cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign stat.full  = (cnt_q == afc_pkg::Q_CNT_W'(afc_pkg::Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + afc_pkg::Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + afc_pkg::Q_PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + afc_pkg::Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - afc_pkg::Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/afc_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module afc_div (
	input  wire                    clk,
	input  wire                    arst_n,
	input  afc_pkg::afc_div_req_t  req,
	output afc_pkg::afc_div_rsp_t  rsp
);

	logic [afc_pkg::STAMP_W-1:0]   rem_q;
	logic [afc_pkg::SUM_W-1:0]     quo_q;
	logic [afc_pkg::STAMP_W-1:0]   divisor_q;
	logic [afc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [afc_pkg::STAMP_W:0]     trial;
	logic [afc_pkg::STAMP_W:0]     diff;
	logic                          ge;

	// Shift in next dividend bit, try subtracting the divisor
	always_comb begin
		trial = {rem_q, quo_q[afc_pkg::SUM_W-1]};
		diff  = trial - {1'b0, divisor_q};
		ge    = (trial >= {1'b0, divisor_q});
	end

	// Quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[afc_pkg::STAMP_W-1:0] : trial[afc_pkg::STAMP_W-1:0];
			quo_q <= {quo_q[afc_pkg::SUM_W-2:0], ge};
		end
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == afc_pkg::DIV_LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + afc_pkg::DIV_CNT_W'(1);
				if (cnt_q == afc_pkg::DIV_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

@@ sv/afc_back.sv @@
// Back end: window mean by reciprocal digits, frequency by divider, result register.
`default_nettype none
module afc_back (
	input  wire                           clk,
	input  wire                           arst_n,
	input  afc_pkg::afc_q_stat_t          q_stat,
	input  wire  [afc_pkg::SUM_W-1:0]     q_data,
	output logic                          q_pop,
	input  wire  [afc_pkg::STAMP_W-1:0]   tick_rate,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [afc_pkg::STAMP_W-1:0]   average_period,
	output logic [afc_pkg::STAMP_W-1:0]   frequency
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MEAN,
		ST_FREQ,
		ST_HOLD
	} state_t;

	state_t                       state_q;
	afc_pkg::afc_div_req_t        div_req_q;
	afc_pkg::afc_div_rsp_t        div_rsp;
	logic [afc_pkg::STAMP_W-1:0]  avg_q;
	logic [afc_pkg::STAMP_W-1:0]  freq_q;
	logic                         out_valid_q;
	logic [afc_pkg::STAMP_W-1:0]  avg_out_q;
	logic [afc_pkg::STAMP_W-1:0]  freq_out_q;

	logic [afc_pkg::SUM_W-1:0]       mean_src_q;
	logic [afc_pkg::CNT_W-1:0]       mean_rem_q;
	logic [afc_pkg::SUM_W-1:0]       mean_quo_q;
	logic [afc_pkg::MEAN_CNT_W-1:0]  mean_cnt_q;

	logic [afc_pkg::MEAN_T_W-1:0]    mean_t;
	logic [afc_pkg::MEAN_PROD_W-1:0] mean_prod;
	logic [afc_pkg::MEAN_DIG_W-1:0]  mean_dig;
	logic [afc_pkg::MEAN_T_W-1:0]    mean_back;
	logic [afc_pkg::MEAN_T_W-1:0]    mean_diff;
	logic [afc_pkg::SUM_W-1:0]       mean_quo;
	logic                            mean_last;
	logic                            out_load;
	logic                            out_drain;

	afc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	// Take a window sum whenever the back end is free
	assign q_pop = (state_q == ST_IDLE) && !q_stat.empty;

	// One mean digit: next 12 sum bits under the running remainder
	always_comb begin
		mean_t    = {mean_rem_q, mean_src_q[afc_pkg::SUM_W-1 -: afc_pkg::MEAN_DIG_W]};
		mean_prod = afc_pkg::MEAN_PROD_W'(mean_t) *
		            afc_pkg::MEAN_PROD_W'(afc_pkg::MEAN_RECIP);
		mean_dig  = mean_prod[afc_pkg::MEAN_SHIFT +: afc_pkg::MEAN_DIG_W];
		mean_back = afc_pkg::MEAN_T_W'(mean_dig) * afc_pkg::MEAN_T_W'(afc_pkg::WINDOW);
		mean_diff = mean_t - mean_back;
		mean_quo  = {mean_quo_q[afc_pkg::SUM_W-afc_pkg::MEAN_DIG_W-1:0], mean_dig};
		mean_last = (mean_cnt_q == afc_pkg::MEAN_LAST);
	end

	// Result register handshake
	assign out_load  = (state_q == ST_HOLD) && (!out_valid_q || out_ready);
	assign out_drain = out_valid_q && out_ready;

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_req_q   <= '0;
			mean_src_q  <= '0;
			mean_rem_q  <= '0;
			mean_quo_q  <= '0;
			mean_cnt_q  <= '0;
			avg_q       <= '0;
			freq_q      <= '0;
			out_valid_q <= 1'b0;
			avg_out_q   <= '0;
			freq_out_q  <= '0;
		end else begin
			div_req_q.start <= (state_q == ST_MEAN) && mean_last;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						mean_src_q <= q_data;
						mean_rem_q <= '0;
						mean_quo_q <= '0;
						mean_cnt_q <= '0;
						state_q    <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					mean_src_q <= {mean_src_q[afc_pkg::SUM_W-afc_pkg::MEAN_DIG_W-1:0],
					               {afc_pkg::MEAN_DIG_W{1'b0}}};
					mean_rem_q <= mean_diff[afc_pkg::CNT_W-1:0];
					mean_quo_q <= mean_quo;
					mean_cnt_q <= mean_cnt_q + afc_pkg::MEAN_CNT_W'(1);
					if (mean_last) begin
						avg_q              <= mean_quo[afc_pkg::STAMP_W-1:0];
						div_req_q.dividend <= afc_pkg::SUM_W'(tick_rate);
						div_req_q.divisor  <= mean_quo[afc_pkg::STAMP_W-1:0];
						state_q            <= ST_FREQ;
					end
				end
				ST_FREQ: begin
					if (div_rsp.done) begin
						freq_q  <= div_rsp.quotient[afc_pkg::STAMP_W-1:0];
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					// wait for the result register to drain
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
				avg_out_q   <= avg_q;
				freq_out_q  <= freq_q;
			end else if (out_drain) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign average_period = avg_out_q;
	assign frequency      = freq_out_q;

endmodule
`default_nettype wire

@@ sv/averaging_reciprocal_frequency_counter_top.sv @@
// Averaging reciprocal frequency counter, top level.
//
// Input channel (in_valid/in_ready, capture_stamp): one beat per timer
// capture at a rising edge of the measured signal. The front end takes one
// beat per cycle while the queue has room, forms the period since the last
// stamp and adds valid periods (nonzero, below 0xFFFFFFF0) into a window sum.
// Output channel (out_valid/out_ready, average_period, frequency): one beat
// per ten valid periods, with the window mean and tick_rate / mean.
// A window sum passes through the queue, the mean digits, the divider
// hand-off, the divider and the result capture before out_valid rises.
// The back end pops the next window sum only after loading the last result.
// A two-entry queue of window sums parts front and back; in_ready drops
// while both entries are waiting and rises when the back end pops one.
// A result waiting on a stalled receiver sits in the output register while
// the back end finishes the next window and holds it; then the queue fills
// and the input stalls.
// cfg_wr_en/cfg_wr_data write tick_rate (reset 1000000 Hz); write only idle.
// Reset clears the previous stamp, the window sum and count, and the queue.
`default_nettype none
module averaging_reciprocal_frequency_counter_top (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire  [afc_pkg::STAMP_W-1:0]   cfg_wr_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [afc_pkg::STAMP_W-1:0]   capture_stamp,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [afc_pkg::STAMP_W-1:0]   average_period,
	output logic [afc_pkg::STAMP_W-1:0]   frequency
);

	logic [afc_pkg::STAMP_W-1:0] tick_rate_q;
	afc_pkg::afc_q_stat_t        q_stat;
	logic                        q_push;
	logic [afc_pkg::SUM_W-1:0]   q_push_data;
	logic                        q_pop;
	logic [afc_pkg::SUM_W-1:0]   q_pop_data;

	// Tick rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= afc_pkg::TICK_RATE_RST;
		end else if (cfg_wr_en) begin
			tick_rate_q <= cfg_wr_data;
		end
	end

	afc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.capture_stamp (capture_stamp),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_data        (q_push_data)
	);

	afc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.stat      (q_stat)
	);

	afc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_stat         (q_stat),
		.q_data         (q_pop_data),
		.q_pop          (q_pop),
		.tick_rate      (tick_rate_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.average_period (average_period),
		.frequency      (frequency)
	);

endmodule
`default_nettype wire

@@ tb/afc_window_checker.sv @@
// Checker for the averaging frequency counter: predicts each window result and compares beats.
`timescale 1ns / 100ps
module afc_window_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [afc_pkg::STAMP_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [afc_pkg::STAMP_W-1:0] capture_stamp,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [afc_pkg::STAMP_W-1:0] average_period,
	input  logic [afc_pkg::STAMP_W-1:0] frequency,
	output int unsigned                 fail_count,
	output int unsigned                 results_owed
);

	typedef struct packed {
		logic [afc_pkg::STAMP_W-1:0] mean_ticks;
		logic [afc_pkg::STAMP_W-1:0] freq_hz;
	} window_result_t;

	// Shadow of the counter state and its tick rate register
	logic [afc_pkg::STAMP_W-1:0] last_stamp   = '0;
	logic [afc_pkg::CNT_W-1:0]   window_fill  = '0;
	logic [afc_pkg::SUM_W-1:0]   window_sum   = '0;
	logic [afc_pkg::STAMP_W-1:0] tick_rate_hz = afc_pkg::TICK_RATE_RST;

	window_result_t owed_results [$];
	int unsigned    mismatch_total = 0;

	task automatic report_mismatch(input string msg);
		mismatch_total++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	// One capture: form the period, accumulate, close the window after WINDOW good periods
	task automatic account_capture(input logic [afc_pkg::STAMP_W-1:0] stamp);
		logic [afc_pkg::STAMP_W-1:0] period;
		logic [afc_pkg::SUM_W-1:0]   mean;
		window_result_t              res;
		period     = stamp - last_stamp;
		last_stamp = stamp;
		if (period != '0 && period < afc_pkg::PERIOD_LIMIT) begin
			window_sum  = window_sum + afc_pkg::SUM_W'(period);
			window_fill = window_fill + 1'b1;
			if (window_fill >= afc_pkg::WINDOW) begin
				mean           = window_sum / afc_pkg::SUM_W'(afc_pkg::WINDOW);
				res.mean_ticks = mean[afc_pkg::STAMP_W-1:0];
				res.freq_hz    = (res.mean_ticks == '0) ? '0
				                                        : tick_rate_hz / res.mean_ticks;
				owed_results.push_back(res);
				window_sum  = '0;
				window_fill = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		window_result_t want;
		if (!arst_n) begin
			last_stamp   = '0;
			window_fill  = '0;
			window_sum   = '0;
			tick_rate_hz = afc_pkg::TICK_RATE_RST;
			owed_results.delete();
		end else begin
			// register write
			if (cfg_wr_en)
				tick_rate_hz = cfg_wr_data;

			// input beat
			if (in_valid && in_ready)
				account_capture(capture_stamp);

			// output beat
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch($sformatf("result beat with none pending: avg %0d freq %0d",
						average_period, frequency));
				end else begin
					want = owed_results.pop_front();
					if (average_period !== want.mean_ticks)
						report_mismatch($sformatf("average_period got %0d want %0d",
							average_period, want.mean_ticks));
					if (frequency !== want.freq_hz)
						report_mismatch($sformatf("frequency got %0d want %0d (avg %0d)",
							frequency, want.freq_hz, want.mean_ticks));
				end
			end
		end
		fail_count   <= mismatch_total;
		results_owed <= owed_results.size();
	end

endmodule

@@ tb/averaging_reciprocal_frequency_counter_top_tb.sv @@
// Testbench top for the averaging frequency counter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module averaging_reciprocal_frequency_counter_top_tb;

	localparam int unsigned PHASES           = 5;
	localparam int unsigned RANDOM_PER_PHASE = 255;
	localparam int unsigned BURST_ITEMS      = 60;
	localparam int unsigned RX_HOLD_CYCLES   = 3000;
	localparam int unsigned DRAIN_CYCLES     = 120;
	localparam int unsigned CYCLE_LIMIT      = 1000000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [afc_pkg::STAMP_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic [afc_pkg::STAMP_W-1:0] capture_stamp;
	logic out_valid;
	logic out_ready;
	logic [afc_pkg::STAMP_W-1:0] average_period;
	logic [afc_pkg::STAMP_W-1:0] frequency;

	int unsigned fail_count;
	int unsigned results_owed;
	int unsigned cycle_count = 0;

	// Sender state
	logic [afc_pkg::STAMP_W-1:0] last_sent = '0;
	logic [afc_pkg::STAMP_W-1:0] pitch_period = 32'd1;
	int unsigned pitch_left = 0;
	bit tx_steady = 1'b0;

	// Long receiver hold, requested by the sender
	logic rx_hold_req = 1'b0;
	logic rx_hold_active;

	averaging_reciprocal_frequency_counter_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.capture_stamp  (capture_stamp),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.average_period (average_period),
		.frequency      (frequency)
	);

	afc_window_checker u_window_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.capture_stamp  (capture_stamp),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.average_period (average_period),
		.frequency      (frequency),
		.fail_count     (fail_count),
		.results_owed   (results_owed)
	);

	always #1 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL averaging_reciprocal_frequency_counter_top");
			$finish;
		end
	end

	// Sender pause after a beat: mostly none or short, a few long
	function automatic int unsigned tx_pause_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (tx_steady || roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 20);
		return $urandom_range(30, 150);
	endfunction

	// Receiver stall length
	function automatic int unsigned rx_pause_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			return 0;
		if (roll < 80)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 30);
		return $urandom_range(60, 200);
	endfunction

	// A good period across the whole range, weighted toward short ones
	function automatic logic [afc_pkg::STAMP_W-1:0] draw_good_period();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return 32'd1;
		if (roll < 35)
			return $urandom_range(2, 64);
		if (roll < 65)
			return $urandom_range(65, 65535);
		if (roll < 85)
			return $urandom_range(65536, 32'h0100_0000);
		if (roll < 95)
			return $urandom_range(32'h0100_0000, afc_pkg::PERIOD_LIMIT - 1);
		return afc_pkg::PERIOD_LIMIT - 1 - $urandom_range(0, 15);
	endfunction

	// Mostly steady pitches and jittery edges, some glitch periods
	function automatic logic [afc_pkg::STAMP_W-1:0] pick_period();
		int unsigned roll;
		if (pitch_left != 0) begin
			pitch_left--;
			return pitch_period;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return '0;
		if (roll < 6)
			return $urandom_range(afc_pkg::PERIOD_LIMIT, 32'hFFFF_FFFF);
		if (roll < 16) begin
			pitch_period = draw_good_period();
			pitch_left   = $urandom_range(9, 30);
			return pitch_period;
		end
		return draw_good_period();
	endfunction

	// One capture beat, held until accepted
	task automatic send_stamp(input logic [afc_pkg::STAMP_W-1:0] stamp);
		int unsigned pause;
		in_valid      <= 1'b1;
		capture_stamp <= stamp;
		last_sent      = stamp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pause = tx_pause_len();
		if (pause != 0) begin
			in_valid      <= 1'b0;
			capture_stamp <= $urandom();
			repeat (pause) @(posedge clk);
		end
	endtask

	task automatic send_period(input logic [afc_pkg::STAMP_W-1:0] period);
		send_stamp(last_sent + period);
	endtask

	// Wait until every window result has come back, then let the back end go quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tick_rate(input logic [afc_pkg::STAMP_W-1:0] rate);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= rate;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Receiver: ready runs, short and long stalls, and one long hold on request
	initial begin : rx_side
		bit hold_taken;
		int unsigned run_len;
		int unsigned pause;
		hold_taken     = 1'b0;
		out_ready      = 1'b0;
		rx_hold_active = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
			                                      : $urandom_range(1, 12);
			repeat (run_len) @(posedge clk);
			if (rx_hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready      <= 1'b0;
				rx_hold_active <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_active <= 1'b0;
			end else begin
				pause = rx_pause_len();
				if (pause != 0) begin
					out_ready <= 1'b0;
					repeat (pause) @(posedge clk);
				end
			end
		end
	end

	// Stimulus
	initial begin : tx_side
		logic [afc_pkg::STAMP_W-1:0] rate_plan [PHASES];
		logic [afc_pkg::STAMP_W-1:0] burst_pitch;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		in_valid      = 1'b0;
		capture_stamp = '0;

		rate_plan[0] = 32'hFFFF_FFFF;
		rate_plan[1] = 32'd1;
		rate_plan[2] = $urandom_range(2, 32'hFFFF_FFFE);
		rate_plan[3] = $urandom_range(1, 5000);
		rate_plan[4] = afc_pkg::TICK_RATE_RST;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edges at the reset tick rate
		send_stamp(32'd7);                        // first edge, measured against zero
		send_period(32'd0);                       // same stamp again
		send_period(32'd1);                       // shortest good period
		send_period(afc_pkg::PERIOD_LIMIT);       // smallest glitch period
		send_period(32'hFFFF_FFFF);               // stamp one tick back
		send_period(afc_pkg::PERIOD_LIMIT - 1);   // longest good period, timer wraps
		send_stamp(32'hFFFF_FFFF);
		send_stamp(32'h0000_0000);                // wrap by one tick
		repeat (5) send_period(afc_pkg::PERIOD_LIMIT - 1);
		repeat (10) send_period(afc_pkg::PERIOD_LIMIT - 1);  // window of longest periods

		// Random phases, one tick rate each
		for (int ph = 0; ph < PHASES; ph++) begin
			settle_block();
			write_tick_rate(rate_plan[ph]);
			if (ph == 2) begin
				// back-to-back windows while the receiver holds off
				rx_hold_req <= 1'b1;
				do
					@(posedge clk);
				while (!rx_hold_active);
				tx_steady   = 1'b1;
				burst_pitch = $urandom_range(1, 5000);
				repeat (BURST_ITEMS) send_period(burst_pitch);
				tx_steady = 1'b0;
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n % 64 == 0)
					tx_steady = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 99) < 4)
					send_stamp($urandom());
				else
					send_period(pick_period());
			end
			tx_steady = 1'b0;
		end

		settle_block();
		if (fail_count == 0) begin
			$display("PASS averaging_reciprocal_frequency_counter_top");
		end else begin
			$display("FAIL averaging_reciprocal_frequency_counter_top");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/afc_pkg.sv
sv/afc_front.sv
sv/afc_fifo.sv
sv/afc_div.sv
sv/afc_back.sv
sv/averaging_reciprocal_frequency_counter_top.sv
tb/afc_window_checker.sv
tb/averaging_reciprocal_frequency_counter_top_tb.sv
